// ----- hw/rtl/satq_pkg.sv -----
// Shared types and constants for the sorted alarm timer queue.
// No dependencies; imported by the interfaces and every module of the block.
package satq_pkg;

  // Field widths of the item and result channels
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 8;

  // Default number of queue entries
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Result kinds
  localparam logic KIND_FIRED   = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_item;   // latch the accepted item
    logic tick_now;    // advance the seconds counter
    logic set_idx;     // insertion scan starts at the tail
    logic rd_head;     // read the head entry
    logic rd_prev;     // read the entry below the scan slot
    logic pop;         // drop the head entry
    logic wr_shift;    // move the read entry up one slot, scan down
    logic wr_new;      // write the new alarm into the scan slot
    logic pend_load;   // hold the head tag as the pending fired alarm
    logic pend_clear;  // pending alarm reported
    logic out_load;    // load the result register
    logic out_src_pend;// result tag from pending alarm, else from the item
    logic out_kind;
    logic out_last;
  } satq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_tick;     // latched item is a tick
    logic delay_zero;  // latched delay is zero
    logic full;        // queue holds QUEUE_DEPTH entries
    logic empty;       // queue holds no entries
    logic idx_zero;    // insertion scan reached the head
    logic reached;     // read deadline has been reached
    logic later;       // read entry fires strictly after the new alarm
    logic out_free;    // result register can take a value this cycle
    logic pend_valid;  // a fired alarm waits to be reported
  } satq_status_t;

endpackage

// ----- hw/rtl/satq_ifs.sv -----
// Valid/ready channel interfaces for items and results of the alarm queue.
// Depends on satq_pkg for field widths.
interface satq_item_if;
  import satq_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [DELAY_W-1:0] delay_seconds;
  logic [TAG_W-1:0]   alarm_tag;

  modport source (output valid, operation, delay_seconds, alarm_tag, input ready);
  modport sink   (input valid, operation, delay_seconds, alarm_tag, output ready);
endinterface

interface satq_result_if;
  import satq_pkg::*;
  logic             valid;
  logic             ready;
  logic             event_kind;
  logic [TAG_W-1:0] fired_tag;
  logic             last_of_run;

  modport source (output valid, event_kind, fired_tag, last_of_run, input ready);
  modport sink   (input valid, event_kind, fired_tag, last_of_run, output ready);
endinterface

// ----- hw/rtl/satq_ctrl.sv -----
// Controller state machine of the alarm queue: sequences ticks and adds.
// Depends on satq_pkg for the command and status structs.
module satq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  satq_pkg::satq_status_t status,
  output satq_pkg::satq_cmd_t    cmd
);
  import satq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK_RD,
    S_TICK_CHK,
    S_FLUSH,
    S_ADD_RD,
    S_ADD_CHK,
    S_REPLY
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;

  assign item_ready = ready;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid && ready) begin
          cmd.take_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_tick) begin
          cmd.tick_now = 1'b1;
          state_next   = S_TICK_RD;
        end else if (status.delay_zero || status.full) begin
          state_next = S_REPLY;
        end else begin
          cmd.set_idx = 1'b1;
          state_next  = S_ADD_RD;
        end
      end
      S_TICK_RD: begin
        if (!status.empty) begin
          cmd.rd_head = 1'b1;
          state_next  = S_TICK_CHK;
        end else if (status.pend_valid) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TICK_CHK: begin
        if (status.reached) begin
          // report the previous fired alarm (not last) before holding this one
          if (!status.pend_valid || status.out_free) begin
            cmd.out_load     = status.pend_valid;
            cmd.out_src_pend = 1'b1;
            cmd.out_kind     = KIND_FIRED;
            cmd.out_last     = 1'b0;
            cmd.pend_load    = 1'b1;
            cmd.pop          = 1'b1;
            state_next       = S_TICK_RD;
          end
        end else if (status.pend_valid) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_src_pend = 1'b1;
          cmd.out_kind     = KIND_FIRED;
          cmd.out_last     = 1'b1;
          cmd.pend_clear   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_ADD_RD: begin
        if (status.idx_zero) begin
          cmd.wr_new = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (status.later) begin
          cmd.wr_shift = 1'b1;
          state_next   = S_ADD_RD;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        // zero delay fires at once, otherwise the queue was full
        if (status.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_src_pend = 1'b0;
          cmd.out_kind     = status.delay_zero ? KIND_FIRED : KIND_DROPPED;
          cmd.out_last     = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b1;
    end else begin
      state <= state_next;
      ready <= (state_next == S_IDLE);
    end
  end

  // Items are only taken while the sequencer is idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |-> (state == S_IDLE))
    else $error("item taken outside idle");

  // Ready is high exactly in idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    ready == (state == S_IDLE))
    else $error("ready out of step with state");

  // A tick advances the clock in the cycle after the item transfer
  a_tick_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_now |-> $past(cmd.take_item))
    else $error("tick without a fresh item");

endmodule

// ----- hw/rtl/satq_dp.sv -----
// Datapath of the alarm queue: seconds counter, circular entry memory,
// scan index, pending fired alarm and result register. Depends on satq_pkg.
module satq_dp #(
  parameter int QUEUE_DEPTH = satq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  satq_pkg::satq_cmd_t         cmd,
  output satq_pkg::satq_status_t      status,
  input  logic                        item_operation,
  input  logic [satq_pkg::DELAY_W-1:0] item_delay,
  input  logic [satq_pkg::TAG_W-1:0]   item_tag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [satq_pkg::TAG_W-1:0]   out_tag,
  output logic                        out_last
);
  import satq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Entry memory
  logic [TIME_W-1:0] mem_dl  [QUEUE_DEPTH];
  logic [TAG_W-1:0]  mem_tag [QUEUE_DEPTH];

  logic [TIME_W-1:0]  now;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               op;
  logic [DELAY_W-1:0] delay;
  logic [TAG_W-1:0]   tag;
  logic               pend_valid;
  logic [TAG_W-1:0]   pend_tag;
  logic [TIME_W-1:0]  rd_dl;
  logic [TAG_W-1:0]   rd_tag;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [TIME_W-1:0]  wr_dl;
  logic [TAG_W-1:0]   wr_tag;
  logic [TIME_W-1:0]  offset;
  logic [TIME_W-1:0]  since;
  logic [CW-1:0]      idx_prev;
  logic               out_free;

  // Logical slot to memory address, relative to the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] slot);
    logic [AW:0] sum;
    sum = {1'b0, hd} + {1'b0, slot[AW-1:0]};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign idx_prev = idx - CW'(1);
  assign out_free = !out_valid || out_ready;

  // Read and write port addressing
  assign rd_en   = cmd.rd_head || cmd.rd_prev;
  assign rd_addr = cmd.rd_head ? head : phys(head, idx_prev);
  assign wr_en   = cmd.wr_shift || cmd.wr_new;
  assign wr_addr = phys(head, idx);
  assign wr_dl   = cmd.wr_shift ? rd_dl  : now + {{(TIME_W-DELAY_W){1'b0}}, delay};
  assign wr_tag  = cmd.wr_shift ? rd_tag : tag;

  // Wrap-safe compares against the current time
  assign since  = now - rd_dl;
  assign offset = rd_dl - now;

  always_comb begin
    status            = '0;
    status.is_tick    = (op == OP_TICK);
    status.delay_zero = (delay == '0);
    status.full       = (count == CW'(QUEUE_DEPTH));
    status.empty      = (count == '0);
    status.idx_zero   = (idx == '0);
    status.reached    = !since[TIME_W-1];
    status.later      = offset > {{(TIME_W-DELAY_W){1'b0}}, delay};
    status.out_free   = out_free;
    status.pend_valid = pend_valid;
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_dl[wr_addr]  <= wr_dl;
      mem_tag[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      rd_dl  <= mem_dl[rd_addr];
      rd_tag <= mem_tag[rd_addr];
    end
  end

  // Item latch and pending tag
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op    <= item_operation;
      delay <= item_delay;
      tag   <= item_tag;
    end
    if (cmd.pend_load) begin
      pend_tag <= rd_tag;
    end
  end

  // Queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      head       <= '0;
      count      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.tick_now) begin
        now <= now + TIME_W'(1);
      end
      if (cmd.pop) begin
        head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
      end else if (cmd.wr_new) begin
        count <= count + CW'(1);
      end
      if (cmd.set_idx) begin
        idx <= count;
      end else if (cmd.wr_shift) begin
        idx <= idx_prev;
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.pend_clear) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= cmd.out_kind;
      out_tag  <= cmd.out_src_pend ? pend_tag : tag;
      out_last <= cmd.out_last;
    end
  end

  // Fill level stays within the memory
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  // No pop of an empty queue, no insert into a full one
  a_pop_insert: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop && count == '0) && !(cmd.wr_new && count == CW'(QUEUE_DEPTH)))
    else $error("pop on empty or insert on full");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten");

  // A pending alarm is reported before it is replaced
  a_pend_reported: assert property (@(posedge clk) disable iff (rst)
    (cmd.pend_load && pend_valid) |-> cmd.out_load)
    else $error("pending alarm lost");

endmodule

// ----- hw/rtl/sorted_alarm_timer_queue_unit.sv -----
// Top level of the sorted alarm timer queue: controller plus datapath.
// Depends on satq_pkg, satq_ifs, satq_ctrl and satq_dp.
//
// Usage:
//   items   : valid/ready channel; operation 0 is a one-second tick, 1 adds an
//             alarm firing delay_seconds from now and reporting alarm_tag.
//   results : valid/ready channel; event_kind 0 = alarm fired, 1 = add dropped
//             because the queue was full; last_of_run marks the final result
//             caused by one item. Successful adds and idle ticks give nothing.
//   An add with zero delay fires at once. Equal deadlines fire in arrival order.
// Sequence:
//   Every item is taken in the idle state and then dispatched. An add scans
//   the queue from its tail through the single-read entry memory, reading
//   each entry and moving it up while it fires later than the new alarm. A
//   tick reads the head and pops it for each fired alarm. Zero delay and full
//   replies go out from a reply state. Ready drops while an item is in work.
// Reset: the time counter is zero and the queue empty; no clearing pass.
// Stall: results sit in an output register; while it is full and not taken,
//   the sequencer holds and the queue state waits, nothing is lost.
module sorted_alarm_timer_queue_unit #(
  parameter int QUEUE_DEPTH = satq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  satq_item_if.sink     items,
  satq_result_if.source results
);
  import satq_pkg::*;

  satq_cmd_t    cmd;
  satq_status_t status;

  satq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .status     (status),
    .cmd        (cmd)
  );

  satq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_operation (items.operation),
    .item_delay     (items.delay_seconds),
    .item_tag       (items.alarm_tag),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_kind       (results.event_kind),
    .out_tag        (results.fired_tag),
    .out_last       (results.last_of_run)
  );

endmodule

// ----- tb/sorted_alarm_timer_queue_unit_tb.sv -----
// Self-checking testbench for sorted_alarm_timer_queue_unit: tick and add stimulus,
// an in-bench model of the deadline-sorted alarm queue, and result checking.
// Depends on satq_pkg, satq_ifs and the RTL of the block.
`timescale 1ns / 100ps

module sorted_alarm_timer_queue_unit_tb;
  import satq_pkg::*;

  localparam int DEPTH         = DEFAULT_QUEUE_DEPTH;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 75;

  typedef struct {
    logic             kind;
    logic [TAG_W-1:0] tag;
    logic             last_flag;
  } alarm_event_t;

  // Alarm queue model plus the store of results still owed by the block
  class alarm_queue_scoreboard;
    bit [TIME_W-1:0]  now_sec;
    bit [TIME_W-1:0]  deadline_q[$];
    bit [TAG_W-1:0]   tag_q[$];
    alarm_event_t     due_events_q[$];
    int errors, n_ticks, n_adds, n_fired, n_dropped, peak_fill;

    function bit is_due(bit [TIME_W-1:0] deadline);
      bit [TIME_W-1:0] gap;
      gap = now_sec - deadline;
      return gap[TIME_W-1] == 1'b0;
    endfunction

    // Work out the results caused by one accepted item
    function void note_item(logic op, logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tag);
      alarm_event_t ev;
      bit [TIME_W-1:0] offset;
      int pos;
      if (op == OP_TICK) begin
        n_ticks++;
        now_sec++;
        while (deadline_q.size() > 0 && is_due(deadline_q[0])) begin
          ev.kind = KIND_FIRED;
          ev.tag  = tag_q[0];
          void'(deadline_q.pop_front());
          void'(tag_q.pop_front());
          ev.last_flag = !(deadline_q.size() > 0 && is_due(deadline_q[0]));
          due_events_q.push_back(ev);
        end
      end else begin
        n_adds++;
        ev.tag = tag;
        ev.last_flag = 1'b1;
        if (delay == '0) begin
          ev.kind = KIND_FIRED;
          due_events_q.push_back(ev);
        end else if (deadline_q.size() >= DEPTH) begin
          ev.kind = KIND_DROPPED;
          due_events_q.push_back(ev);
        end else begin
          // insert after every entry that fires no later than the new one
          pos = 0;
          while (pos < deadline_q.size()) begin
            offset = deadline_q[pos] - now_sec;
            if (offset > {{(TIME_W-DELAY_W){1'b0}}, delay}) break;
            pos++;
          end
          deadline_q.insert(pos, now_sec + delay);
          tag_q.insert(pos, tag);
          if (deadline_q.size() > peak_fill) peak_fill = deadline_q.size();
        end
      end
    endfunction

    // Compare one transfer on the result channel with the oldest pending result
    function void check_result(logic kind, logic [TAG_W-1:0] tag, logic last_flag);
      alarm_event_t ev;
      if (due_events_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind=%0d tag=%02h last=%0d",
                 $time, kind, tag, last_flag);
        return;
      end
      ev = due_events_q.pop_front();
      if (kind === KIND_FIRED) n_fired++;
      else n_dropped++;
      if (kind !== ev.kind || tag !== ev.tag || last_flag !== ev.last_flag) begin
        errors++;
        $display("%0t: result mismatch, expected kind=%0d tag=%02h last=%0d,",
                 $time, ev.kind, ev.tag, ev.last_flag);
        $display("    got kind=%0d tag=%02h last=%0d", kind, tag, last_flag);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  satq_item_if   items_if ();
  satq_result_if results_if ();

  alarm_queue_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;

  sorted_alarm_timer_queue_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    results_if.ready = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.event_kind, results_if.fired_tag, results_if.last_of_run);
  end

  // Offer one item, with random idle cycles first; returns after its transfer
  task automatic send_item(logic op, logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid         <= 1'b1;
    items_if.operation     <= op;
    items_if.delay_seconds <= delay;
    items_if.alarm_tag     <= tag;
    do @(posedge clk); while (!items_if.ready);
    sb.note_item(op, delay, tag);
  endtask

  // Random item; delays mostly short so alarms fire, a few span the full field
  task automatic send_random_item(int add_pct);
    logic [DELAY_W-1:0] delay;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) delay = '0;
    else if (pick < 12) delay = DELAY_W'($urandom());
    else delay = DELAY_W'($urandom_range(1, 12));
    if ($urandom_range(99) < add_pct) send_item(OP_ADD, delay, TAG_W'($urandom()));
    else send_item(OP_TICK, DELAY_W'($urandom()), TAG_W'($urandom()));
  endtask

  // Stop offering and let every owed result arrive
  task automatic wait_drained();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (sb.due_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall);
    int add_pct;
    idle_pct  = idle;
    stall_pct = stall;
    add_pct   = 50;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 30;
          1: add_pct = 55;
          default: add_pct = 80;
        endcase
      end
      send_random_item(add_pct);
    end
    wait_drained();
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.operation = OP_TICK;
    items_if.delay_seconds = '0;
    items_if.alarm_tag = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: idle tick, zero delay at tag extremes, equal deadlines,
    // longest delay, fill to full, drop, zero delay while full, drain
    send_item(OP_TICK, '1, '1);
    send_item(OP_ADD, '0, 8'h00);
    send_item(OP_ADD, '0, 8'hFF);
    send_item(OP_ADD, 16'd1, 8'h11);
    send_item(OP_ADD, 16'd1, 8'h22);
    send_item(OP_ADD, 16'hFFFF, 8'hAA);
    send_item(OP_TICK, '0, '0);
    for (int i = 0; i < DEPTH - 1; i++)
      send_item(OP_ADD, DELAY_W'(1 + i % 3), TAG_W'(8'h40 + i));
    send_item(OP_ADD, 16'd5, 8'hEE);
    send_item(OP_ADD, '0, 8'h5A);
    repeat (3) send_item(OP_TICK, '0, '0);
    wait_drained();

    // No idling on either side
    run_phase(0, 0);

    // Long result hold-off while items keep coming, so the input stalls
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++) begin
      if (i % 4 == 3) send_item(OP_TICK, '0, TAG_W'($urandom()));
      else if (i % 2 == 0) send_item(OP_ADD, '0, TAG_W'($urandom()));
      else send_item(OP_ADD, DELAY_W'($urandom_range(1, 4)), TAG_W'($urandom()));
    end
    wait_drained();

    run_phase(80, 0);
    run_phase(0, 80);
    run_phase(6, 6);

    $display("Ran %0d ticks and %0d adds: %0d alarms reported as fired, %0d adds dropped,",
             sb.n_ticks, sb.n_adds, sb.n_fired, sb.n_dropped);
    $display("peak queue occupancy %0d of %0d, %0d mismatches.",
             sb.peak_fill, DEPTH, sb.errors);
    if (sb.errors == 0 && sb.due_events_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
